[hw/rtl/dcta_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dcta_pkg: shared types and constants for the duty-cycle tilt angle block
// Holds the sequencer state type, the side codes and the arcsine table.
// ----------------------------------------------------------------------------
package dcta_pkg;

    // Sequencer states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_WRITE
    } t_state;

    // Side flag codes.
    typedef logic [1:0] t_side;
    localparam t_side SIDE_IN_RANGE = 2'd0;
    localparam t_side SIDE_BELOW    = 2'd1;
    localparam t_side SIDE_ABOVE    = 2'd2;

    // The quotient floor(65536*high/period) never exceeds 65536: 17 bits.
    localparam int QUOT_BITS = 17;
    localparam int STEP_W    = 5;
    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(QUOT_BITS - 1);

    // Widths of the signed datapath.
    localparam int OFFSET_W = 17;
    localparam int TILT_W   = 18;
    localparam int ANGLE_W  = 7;

    localparam logic signed [TILT_W-1:0] DUTY_HALF = 18'sd32768;
    // Division by 64 is a right shift by six.
    localparam int QSHIFT = 6;
    localparam int QMAG_W = TILT_W - QSHIFT;
    localparam logic [QMAG_W-1:0] MAG_LIMIT = QMAG_W'(110);
    localparam logic [ANGLE_W-1:0] SAT_ANGLE = 7'd61;

    localparam int ASIN_DEPTH = 112;
    localparam logic [5:0] ASIN_TABLE [0:ASIN_DEPTH-1] = '{
         0,  0,  1,  1,  2,  2,  3,  3,  4,  4,  4,  5,  5,  6,  6,  7,
         7,  8,  8,  8,  9,  9, 10, 10, 11, 11, 12, 12, 13, 13, 13, 14,
        14, 15, 15, 16, 16, 17, 17, 18, 18, 19, 19, 20, 20, 21, 21, 22,
        22, 22, 23, 23, 24, 24, 25, 25, 26, 26, 27, 27, 28, 28, 29, 29,
        30, 31, 31, 32, 32, 33, 33, 34, 34, 35, 35, 36, 36, 37, 38, 38,
        39, 39, 40, 40, 41, 42, 42, 43, 44, 44, 45, 45, 46, 47, 47, 48,
        49, 49, 50, 51, 52, 52, 53, 54, 55, 55, 56, 57, 58, 59, 60, 61
    };

    // Arcsine lookup in degrees; indexes past the table give the saturated angle.
    function automatic logic [ANGLE_W-1:0] asin_lookup(input logic [6:0] idx);
        logic [ANGLE_W-1:0] res;
        begin
            if (int'(idx) < ASIN_DEPTH) begin
                res = {1'b0, ASIN_TABLE[idx]};
            end else begin
                res = SAT_ANGLE;
            end
            return res;
        end
    endfunction

endpackage
`default_nettype wire

[hw/rtl/dcta_if.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dcta_if: valid/ready channels of the duty-cycle tilt angle block
// One interface carries pulse measurements in, the other carries angle results out.
// ----------------------------------------------------------------------------
interface dcta_in_if #(
    parameter int COUNT_WIDTH = 16
);
    logic                   valid;
    logic                   ready;
    logic                   func;
    logic                   axis;
    logic [COUNT_WIDTH-1:0] high_time;
    logic [COUNT_WIDTH-1:0] period;

    modport source (output valid, output func, output axis, output high_time,
                    output period, input ready);
    modport sink   (input valid, input func, input axis, input high_time,
                    input period, output ready);
endinterface

interface dcta_out_if;
    logic              valid;
    logic              ready;
    logic signed [6:0] angle_deg;
    logic [1:0]        side;
    logic signed [17:0] tilt_raw;
    logic              error;

    modport source (output valid, output angle_deg, output side, output tilt_raw,
                    output error, input ready);
    modport sink   (input valid, input angle_deg, input side, input tilt_raw,
                    input error, output ready);
endinterface
`default_nettype wire

[hw/rtl/duty_cycle_tilt_angle.sv]
`timescale 1ns / 1ps
`default_nettype none
// Sequence: a valid pulse goes from ST_IDLE through the 17 steps of ST_DIV to ST_WRITE,
// which registers the result once the output is free; an invalid one skips ST_DIV.
// The restoring divider produces one quotient bit per cycle, and the block holds off
// new input until the result is written, so it takes one item at a time.
// Reset: synchronous and active low; clears the sequencer, the output valid flag
// and both axis offsets.
// ----------------------------------------------------------------------------
// duty_cycle_tilt_angle: tilt angle from a duty-cycle accelerometer
// Divides high time by period with a shared restoring divider, subtracts the
// axis offset and maps it through an arcsine table, or on calibration stores the offset.
// ----------------------------------------------------------------------------
module duty_cycle_tilt_angle #(
    parameter int COUNT_WIDTH = 16
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    dcta_in_if.sink     i_in,
    dcta_out_if.source  o_out
);

    localparam int CW = COUNT_WIDTH;

    // Sequencer and divider registers.
    dcta_pkg::t_state                 r_state, n_state;
    logic [dcta_pkg::STEP_W-1:0]      r_step, n_step;
    logic [CW:0]                      r_rem, n_rem;
    logic [CW-1:0]                    r_per, n_per;
    logic [dcta_pkg::QUOT_BITS-1:0]   r_quot, n_quot;
    logic                             r_func, n_func;
    logic                             r_axis, n_axis;
    logic                             r_err, n_err;

    // Axis offsets, zero after reset.
    logic signed [dcta_pkg::OFFSET_W-1:0] r_off [0:1];
    logic                                 n_off_we;

    // Output register.
    logic                                r_out_valid, n_out_valid;
    logic signed [dcta_pkg::ANGLE_W-1:0] r_angle, n_angle;
    dcta_pkg::t_side                     r_side, n_side;
    logic signed [dcta_pkg::TILT_W-1:0]  r_tilt, n_tilt;
    logic                                r_error, n_error;

    // Datapath of one divider step. On the first step the remainder holds the
    // high time itself, which decides the top quotient bit without a shift.
    logic [CW:0] s_trial;
    logic        s_ge;

    // Result datapath.
    logic signed [dcta_pkg::TILT_W-1:0]  s_reading;
    logic signed [dcta_pkg::TILT_W-1:0]  s_diff;
    logic [dcta_pkg::TILT_W-1:0]         s_mag;
    logic [dcta_pkg::QMAG_W-1:0]         s_qmag;
    logic [dcta_pkg::ANGLE_W-1:0]        s_angle_mag;
    logic signed [dcta_pkg::ANGLE_W-1:0] s_angle;
    logic                                s_in_xfer;
    logic                                s_out_free;

    assign s_in_xfer  = i_in.valid && i_in.ready;
    assign s_out_free = !r_out_valid || o_out.ready;

    assign s_trial = (r_step == '0) ? r_rem : {r_rem[CW-1:0], 1'b0};
    assign s_ge    = (s_trial >= {1'b0, r_per});

    always_comb begin
        s_reading = $signed({1'b0, r_quot}) - dcta_pkg::DUTY_HALF;
        s_diff    = s_reading - dcta_pkg::TILT_W'(r_off[r_axis]);
        s_mag     = s_diff[dcta_pkg::TILT_W-1] ? dcta_pkg::TILT_W'(-s_diff)
                                               : dcta_pkg::TILT_W'(s_diff);
        // Truncation toward zero of the signed quotient is the magnitude shifted.
        s_qmag    = s_mag[dcta_pkg::TILT_W-1:dcta_pkg::QSHIFT];
        if (s_qmag > dcta_pkg::MAG_LIMIT) begin
            s_angle_mag = dcta_pkg::SAT_ANGLE;
        end else begin
            s_angle_mag = dcta_pkg::asin_lookup(s_qmag[6:0]);
        end
        // A zero magnitude stays zero after negation, so the sign of the
        // difference can stand for the sign of the quotient.
        s_angle = s_diff[dcta_pkg::TILT_W-1] ? -$signed(s_angle_mag)
                                             : $signed(s_angle_mag);
    end

    // Next state and outputs of the sequencer.
    always_comb begin
        n_state     = r_state;
        n_step      = r_step;
        n_rem       = r_rem;
        n_per       = r_per;
        n_quot      = r_quot;
        n_func      = r_func;
        n_axis      = r_axis;
        n_err       = r_err;
        n_off_we    = 1'b0;
        n_out_valid = r_out_valid && !o_out.ready;
        n_angle     = r_angle;
        n_side      = r_side;
        n_tilt      = r_tilt;
        n_error     = r_error;

        case (r_state)
            dcta_pkg::ST_IDLE: begin
                if (s_in_xfer) begin
                    n_func = i_in.func;
                    n_axis = i_in.axis;
                    n_rem  = {1'b0, i_in.high_time};
                    n_per  = i_in.period;
                    n_step = '0;
                    n_quot = '0;
                    // A zero period or a high time past the period skips the divider.
                    if (i_in.period == '0 || i_in.high_time > i_in.period) begin
                        n_err   = 1'b1;
                        n_state = dcta_pkg::ST_WRITE;
                    end else begin
                        n_err   = 1'b0;
                        n_state = dcta_pkg::ST_DIV;
                    end
                end
            end
            dcta_pkg::ST_DIV: begin
                n_rem  = s_ge ? (s_trial - {1'b0, r_per}) : s_trial;
                n_quot = {r_quot[dcta_pkg::QUOT_BITS-2:0], s_ge};
                n_step = r_step + 1'b1;
                if (r_step == dcta_pkg::LAST_STEP) begin
                    n_state = dcta_pkg::ST_WRITE;
                end
            end
            dcta_pkg::ST_WRITE: begin
                if (s_out_free) begin
                    n_out_valid = 1'b1;
                    n_state     = dcta_pkg::ST_IDLE;
                    if (r_err) begin
                        n_angle = '0;
                        n_side  = dcta_pkg::SIDE_IN_RANGE;
                        n_tilt  = '0;
                        n_error = 1'b1;
                    end else begin
                        n_tilt  = s_diff;
                        n_error = 1'b0;
                        if (r_func) begin
                            // Calibration stores the reading and reports no angle.
                            n_off_we = 1'b1;
                            n_angle  = '0;
                            n_side   = dcta_pkg::SIDE_IN_RANGE;
                        end else begin
                            n_angle = s_angle;
                            if (s_angle < -7'sd60) begin
                                n_side = dcta_pkg::SIDE_BELOW;
                            end else if (s_angle > 7'sd60) begin
                                n_side = dcta_pkg::SIDE_ABOVE;
                            end else begin
                                n_side = dcta_pkg::SIDE_IN_RANGE;
                            end
                        end
                    end
                end
            end
            default: begin
                n_state = dcta_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= dcta_pkg::ST_IDLE;
            r_out_valid <= 1'b0;
            r_off[0]    <= '0;
            r_off[1]    <= '0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            if (n_off_we) begin
                r_off[r_axis] <= s_reading[dcta_pkg::OFFSET_W-1:0];
            end
        end
    end

    // Payload and datapath registers need no reset.
    always_ff @(posedge i_clk) begin
        r_step  <= n_step;
        r_rem   <= n_rem;
        r_per   <= n_per;
        r_quot  <= n_quot;
        r_func  <= n_func;
        r_axis  <= n_axis;
        r_err   <= n_err;
        r_angle <= n_angle;
        r_side  <= n_side;
        r_tilt  <= n_tilt;
        r_error <= n_error;
    end

    assign i_in.ready      = (r_state == dcta_pkg::ST_IDLE);
    assign o_out.valid     = r_out_valid;
    assign o_out.angle_deg = r_angle;
    assign o_out.side      = r_side;
    assign o_out.tilt_raw  = r_tilt;
    assign o_out.error     = r_error;

endmodule
`default_nettype wire

[hw/rtl/dcta_checker.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dcta_checker: port-level checks of the duty-cycle tilt angle block
// Watches both channels and is bound to the top level.
// ----------------------------------------------------------------------------
module dcta_checker (
    input wire              i_clk,
    input wire              i_rst_n,
    input wire              i_in_valid,
    input wire              i_in_ready,
    input wire              i_out_valid,
    input wire              i_out_ready,
    input wire signed [6:0] i_angle_deg,
    input wire [1:0]        i_side,
    input wire signed [17:0] i_tilt_raw,
    input wire              i_error
);

    // An error result carries no angle, side or raw tilt.
    a_error_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_error) |->
            (i_angle_deg == 7'sd0 && i_side == dcta_pkg::SIDE_IN_RANGE &&
             i_tilt_raw == 18'sd0))
        else $error("error result with nonzero payload");

    // The side flag agrees with the saturated angle.
    a_side_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |->
            ((i_side == dcta_pkg::SIDE_ABOVE) == (i_angle_deg == 7'sd61) &&
             (i_side == dcta_pkg::SIDE_BELOW) == (i_angle_deg == -7'sd61)))
        else $error("side flag disagrees with angle");

    // The angle stays within the saturation limits.
    a_angle_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_angle_deg >= -7'sd61 && i_angle_deg <= 7'sd61))
        else $error("angle out of range");

    // One item at a time: the input closes right after a transfer.
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready) |=> !i_in_ready)
        else $error("input ready right after a transfer");

    // A stalled result holds.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=>
            (i_out_valid && $stable(i_angle_deg) && $stable(i_side) &&
             $stable(i_tilt_raw) && $stable(i_error)))
        else $error("stalled result changed");

endmodule

bind duty_cycle_tilt_angle dcta_checker u_dcta_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_angle_deg (o_out.angle_deg),
    .i_side      (o_out.side),
    .i_tilt_raw  (o_out.tilt_raw),
    .i_error     (o_out.error)
);
`default_nettype wire
